// ===== src/prm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prm_pkg
// Shared constants, register codes and types of the power rail monitor.
// ----------------------------------------------------------------------------
package prm_pkg;

  // Default sizes
  localparam int unsigned SAMPLE_BITS_DEF   = 12;
  localparam int unsigned CONTACT_COUNT_DEF = 11;

  // Fixed result widths
  localparam int unsigned MV_W    = 16;
  localparam int unsigned MA_W    = 11;
  localparam int unsigned PCT_W   = 7;
  localparam int unsigned BMA_W   = 14;
  localparam int unsigned CHG_W   = 17;
  localparam int unsigned FAULT_W = 6;
  localparam int unsigned LIMIT_W = 16;

  // Scaling
  localparam int unsigned MV_FULL_SCALE      = 36300;
  localparam int unsigned MA_FULL_SCALE      = 1650;
  localparam int unsigned SOC_LOW_MV         = 18000;
  localparam int unsigned SOC_HIGH_MV        = 25200;
  localparam int unsigned SOC_SPAN_W         = 13;   // (high - low) mV fits 13 bits
  localparam int unsigned SOC_PRE_SHIFT      = 3;    // 72 = 8 * 9
  localparam int unsigned SOC_NINTH_RECIP    = 7282; // ceil(2^16 / 9)
  localparam int unsigned SOC_NINTH_SHIFT    = 16;
  localparam int unsigned SOC_FULL_PCT       = 100;
  localparam int unsigned CHARGE_MIN_DIFF_MV = 500;

  // Fault word bits
  localparam int unsigned FAULT_COLLISION = 0;
  localparam int unsigned FAULT_UPLIFT    = 1;
  localparam int unsigned FAULT_LEFT_OC   = 2;
  localparam int unsigned FAULT_RIGHT_OC  = 3;
  localparam int unsigned FAULT_BLADE_OC  = 4;
  localparam int unsigned FAULT_IMU       = 5;

  // Contact groups
  localparam int unsigned COLL_LO   = 0;
  localparam int unsigned COLL_HI   = 3;
  localparam int unsigned UPLIFT_LO = 4;
  localparam int unsigned UPLIFT_HI = 5;

  // Register reset values
  localparam logic [LIMIT_W-1:0] LEFT_LIMIT_RST  = 16'd5000;
  localparam logic [LIMIT_W-1:0] RIGHT_LIMIT_RST = 16'd5000;
  localparam logic [LIMIT_W-1:0] BLADE_LIMIT_RST = 16'd8000;

  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEFT_LIMIT  = 2'd0,
    REG_RIGHT_LIMIT = 2'd1,
    REG_BLADE_LIMIT = 2'd2,
    REG_IMU_PRESENT = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] left_limit_ma;
    logic [LIMIT_W-1:0] right_limit_ma;
    logic [LIMIT_W-1:0] blade_limit_ma;
    logic               imu_present;
  } cfg_t;

endpackage

// ===== src/power_rail_monitor_fault_flags_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// power_rail_monitor_fault_flags_top
// Scales one converter frame to mV / mA, estimates charge state and charge
// current, and packs contact and overcurrent faults into a fault word.
// ----------------------------------------------------------------------------
//
//  channel   handshake            moves
//  -------   ------------------   ---------------------------------------
//  input     start / busy         one frame word: five samples, pin levels
//  result    out_valid (strobe)   one result word, valid for one cycle
//  config    cfg_valid/cfg_ready  register index + 16-bit data
//
//  Cycles: one frame word per clock; busy stays low. A result word passes
//  two registers after its frame is taken: the first register holds the
//  constant products, the second the finished result.
//  Reset: synchronous, active low; clears the pipeline valids and loads the
//  limit registers with 5000 / 5000 / 8000 mA and IMU absent.
//  Stalls: none. The receiver must take out_valid words as they come.
//
module power_rail_monitor_fault_flags_top
  import prm_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS   = SAMPLE_BITS_DEF,
  parameter int unsigned CONTACT_COUNT = CONTACT_COUNT_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,

  // frame input
  input  logic                     start,
  output logic                     busy,
  input  logic [SAMPLE_BITS-1:0]   in_battery_raw,
  input  logic [SAMPLE_BITS-1:0]   in_left_raw,
  input  logic [SAMPLE_BITS-1:0]   in_right_raw,
  input  logic [SAMPLE_BITS-1:0]   in_blade_raw,
  input  logic [SAMPLE_BITS-1:0]   in_adapter_raw,
  input  logic [CONTACT_COUNT-1:0] in_contact_pins,

  // result output
  output logic                     out_valid,
  output logic [MV_W-1:0]          out_battery_mv,
  output logic [MV_W-1:0]          out_adp_mv,
  output logic [PCT_W-1:0]         out_charge_pct,
  output logic [MA_W-1:0]          out_left_ma,
  output logic [MA_W-1:0]          out_rgt_ma,
  output logic [MA_W-1:0]          out_bld_ma,
  output logic signed [BMA_W-1:0]  out_battery_ma,
  output logic [CHG_W-1:0]         out_charge_ma,
  output logic [CONTACT_COUNT-1:0] out_triggered_mask,
  output logic [FAULT_W-1:0]       out_fault_word,

  // configuration
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [LIMIT_W-1:0]       cfg_data
);

  // Exact mV * 2^SAMPLE_BITS needs 16 bits above the sample bits
  localparam int unsigned NUM_W = SAMPLE_BITS + MV_W;
  localparam int unsigned MAP_W = SAMPLE_BITS + MA_W;
  localparam logic [NUM_W-1:0] SOC_LOW_NUM  = NUM_W'(SOC_LOW_MV) << SAMPLE_BITS;
  localparam logic [NUM_W-1:0] SOC_HIGH_NUM = NUM_W'(SOC_HIGH_MV) << SAMPLE_BITS;
  localparam int unsigned Q_W   = SOC_SPAN_W - SOC_PRE_SHIFT;
  localparam int unsigned QP_W  = Q_W + SOC_SPAN_W + 1;
  localparam int unsigned SUM_W = MA_W + 2;

  cfg_t cfg_regs;

  prm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_regs  (cfg_regs)
  );

  // Busy is never raised: a frame is taken whenever start is high
  assign busy = 1'b0;
  logic accept;
  assign accept = start && !busy;

  // --------------------------------------------------------------------------
  // Stage 1: constant products. Battery keeps the full product, since the
  // charge state needs the untruncated value; the rest keep the integer part.
  // --------------------------------------------------------------------------
  logic [NUM_W-1:0] bat_num_nxt, adp_num_nxt;
  logic [MAP_W-1:0] l_prod_nxt, r_prod_nxt, b_prod_nxt;

  assign bat_num_nxt = NUM_W'(in_battery_raw) * NUM_W'(MV_FULL_SCALE);
  assign adp_num_nxt = NUM_W'(in_adapter_raw) * NUM_W'(MV_FULL_SCALE);
  assign l_prod_nxt  = MAP_W'(in_left_raw)  * MAP_W'(MA_FULL_SCALE);
  assign r_prod_nxt  = MAP_W'(in_right_raw) * MAP_W'(MA_FULL_SCALE);
  assign b_prod_nxt  = MAP_W'(in_blade_raw) * MAP_W'(MA_FULL_SCALE);

  logic                     s1_valid_r;
  logic [NUM_W-1:0]         s1_bat_num_r;
  logic [MV_W-1:0]          s1_adp_mv_r;
  logic [MA_W-1:0]          s1_l_ma_r, s1_r_ma_r, s1_b_ma_r;
  logic [CONTACT_COUNT-1:0] s1_trig_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_bat_num_r <= bat_num_nxt;
      s1_adp_mv_r  <= adp_num_nxt[NUM_W-1:SAMPLE_BITS];
      s1_l_ma_r    <= l_prod_nxt[MAP_W-1:SAMPLE_BITS];
      s1_r_ma_r    <= r_prod_nxt[MAP_W-1:SAMPLE_BITS];
      s1_b_ma_r    <= b_prod_nxt[MAP_W-1:SAMPLE_BITS];
      s1_trig_r    <= ~in_contact_pins;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: charge state, currents, faults
  // --------------------------------------------------------------------------
  logic [MV_W-1:0]       bat_mv;
  logic [NUM_W-1:0]      soc_diff;
  logic [SOC_SPAN_W-1:0] soc_mv;      // mV above the low threshold
  logic [Q_W-1:0]        soc_oct;     // that, over 8
  logic [QP_W-1:0]       soc_prod;    // over 9 by reciprocal
  logic [PCT_W-1:0]      pct_nxt;

  assign bat_mv   = s1_bat_num_r[NUM_W-1:SAMPLE_BITS];
  assign soc_diff = s1_bat_num_r - SOC_LOW_NUM;
  assign soc_mv   = soc_diff[SAMPLE_BITS +: SOC_SPAN_W];
  assign soc_oct  = soc_mv[SOC_SPAN_W-1:SOC_PRE_SHIFT];
  assign soc_prod = QP_W'(soc_oct) * QP_W'(SOC_NINTH_RECIP);

  always_comb begin
    if (s1_bat_num_r >= SOC_HIGH_NUM) begin
      pct_nxt = PCT_W'(SOC_FULL_PCT);
    end else if (s1_bat_num_r <= SOC_LOW_NUM) begin
      pct_nxt = '0;
    end else begin
      pct_nxt = soc_prod[SOC_NINTH_SHIFT +: PCT_W];
    end
  end

  // Battery current is the negated motor sum, 14-bit two's complement
  logic [SUM_W-1:0] ma_sum;
  logic [BMA_W-1:0] bat_ma_nxt;
  assign ma_sum     = SUM_W'(s1_l_ma_r) + SUM_W'(s1_r_ma_r) + SUM_W'(s1_b_ma_r);
  assign bat_ma_nxt = BMA_W'(0) - BMA_W'(ma_sum);

  // Charging only when the adapter leads the battery by more than 500 mV
  logic [MV_W:0]    chg_thresh, chg_diff;
  logic [CHG_W-1:0] chg_ma_nxt;
  assign chg_thresh = {1'b0, bat_mv} + (MV_W + 1)'(CHARGE_MIN_DIFF_MV);
  assign chg_diff   = {1'b0, s1_adp_mv_r} - {1'b0, bat_mv};
  assign chg_ma_nxt = ({1'b0, s1_adp_mv_r} > chg_thresh) ? CHG_W'({chg_diff, 1'b0}) : '0;

  logic [FAULT_W-1:0] fault_nxt;
  always_comb begin
    fault_nxt                  = '0;
    fault_nxt[FAULT_COLLISION] = |s1_trig_r[COLL_HI:COLL_LO];
    fault_nxt[FAULT_UPLIFT]    = |s1_trig_r[UPLIFT_HI:UPLIFT_LO];
    fault_nxt[FAULT_LEFT_OC]   = LIMIT_W'(s1_l_ma_r) > cfg_regs.left_limit_ma;
    fault_nxt[FAULT_RIGHT_OC]  = LIMIT_W'(s1_r_ma_r) > cfg_regs.right_limit_ma;
    fault_nxt[FAULT_BLADE_OC]  = LIMIT_W'(s1_b_ma_r) > cfg_regs.blade_limit_ma;
    fault_nxt[FAULT_IMU]       = !cfg_regs.imu_present;
  end

  // Result register
  logic                     out_valid_r;
  logic [MV_W-1:0]          bat_mv_r, adp_mv_r;
  logic [PCT_W-1:0]         pct_r;
  logic [MA_W-1:0]          l_ma_r, r_ma_r, b_ma_r;
  logic [BMA_W-1:0]         bat_ma_r;
  logic [CHG_W-1:0]         chg_ma_r;
  logic [CONTACT_COUNT-1:0] trig_r;
  logic [FAULT_W-1:0]       fault_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      bat_mv_r <= bat_mv;
      adp_mv_r <= s1_adp_mv_r;
      pct_r    <= pct_nxt;
      l_ma_r   <= s1_l_ma_r;
      r_ma_r   <= s1_r_ma_r;
      b_ma_r   <= s1_b_ma_r;
      bat_ma_r <= bat_ma_nxt;
      chg_ma_r <= chg_ma_nxt;
      trig_r   <= s1_trig_r;
      fault_r  <= fault_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_battery_mv     = bat_mv_r;
  assign out_adp_mv         = adp_mv_r;
  assign out_charge_pct     = pct_r;
  assign out_left_ma        = l_ma_r;
  assign out_rgt_ma         = r_ma_r;
  assign out_bld_ma         = b_ma_r;
  assign out_battery_ma     = $signed(bat_ma_r);
  assign out_charge_ma      = chg_ma_r;
  assign out_triggered_mask = trig_r;
  assign out_fault_word     = fault_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // every frame taken yields a result word once it has passed both registers
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##2 out_valid)
    else $error("result word missing two clocks after frame");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, 2))
    else $error("result word without a frame");

  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_charge_pct <= PCT_W'(SOC_FULL_PCT)))
    else $error("charge percent above full");

  a_charge_gate: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_charge_ma != '0)) |->
      ((MV_W + 1)'(out_adp_mv) >
       (MV_W + 1)'(out_battery_mv) + (MV_W + 1)'(CHARGE_MIN_DIFF_MV)))
    else $error("charge current without adapter lead");

  a_collision: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (out_fault_word[FAULT_COLLISION] == (|out_triggered_mask[COLL_HI:COLL_LO])))
    else $error("collision fault disagrees with triggered mask");

endmodule

// ===== src/prm_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prm_cfg
// Limit and presence registers, written through the config channel.
// ----------------------------------------------------------------------------
module prm_cfg
  import prm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LIMIT_W-1:0]   cfg_data,
  output cfg_t                 cfg_regs
);

  cfg_t regs_r;
  cfg_t regs_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    regs_nxt = regs_r;
    if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_LEFT_LIMIT:  regs_nxt.left_limit_ma  = cfg_data;
        REG_RIGHT_LIMIT: regs_nxt.right_limit_ma = cfg_data;
        REG_BLADE_LIMIT: regs_nxt.blade_limit_ma = cfg_data;
        REG_IMU_PRESENT: regs_nxt.imu_present    = cfg_data[0];
        default:         regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.left_limit_ma  <= LEFT_LIMIT_RST;
      regs_r.right_limit_ma <= RIGHT_LIMIT_RST;
      regs_r.blade_limit_ma <= BLADE_LIMIT_RST;
      regs_r.imu_present    <= 1'b0;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  assign cfg_regs = regs_r;

endmodule
